// ===== rtl/mtnx_pkg.sv =====
// ----------------------------------------------------------------------------
// mtnx_pkg
// Shared types, constants and the control program of the metatile expander.
// ----------------------------------------------------------------------------
package mtnx_pkg;

   // default sizes and fixed constants
   localparam int          MAP_CELLS_DEF       = 192;
   localparam int          ATTRIBUTE_BYTES_DEF = 48;
   localparam logic [15:0] BASE_RESET          = 16'h2000;
   localparam logic [15:0] ATTR_OFFSET         = 16'h03C0;

   // control program size and step indexes
   localparam int STEP_COUNT = 7;
   localparam int STEP_W     = $clog2(STEP_COUNT);

   typedef logic [STEP_W-1:0] step_type;

   localparam step_type STEP_IDLE   = STEP_W'(0);
   localparam step_type STEP_TILE0  = STEP_W'(1);
   localparam step_type STEP_TILE1  = STEP_W'(2);
   localparam step_type STEP_TILE2  = STEP_W'(3);
   localparam step_type STEP_TILE3  = STEP_W'(4);
   localparam step_type STEP_APRIME = STEP_W'(5);
   localparam step_type STEP_AEMIT  = STEP_W'(6);

   // jump conditions: jump to target when true, else fall through
   typedef enum logic [1:0] {
      COND_NEVER     = 2'd0,
      COND_NOT_START = 2'd1,
      COND_NOT_FINAL = 2'd2,
      COND_NOT_K_END = 2'd3
   } cond_type;

   // how the last flag of an emitted item is formed
   typedef enum logic [1:0] {
      LAST_NONE      = 2'd0,
      LAST_NOT_FINAL = 2'd1,
      LAST_K_END     = 2'd2
   } last_type;

   // one control word
   typedef struct packed {
      logic     accept;
      logic     emit;
      logic     tile_lo;
      logic     tile_hi;
      logic     attr_write;
      logic     attr_start;
      logic     attr_emit;
      logic     pos_inc;
      last_type last_sel;
      cond_type cond;
      step_type target;
   } ctrl_type;

   // sequencer to datapath
   typedef struct packed {
      ctrl_type word;
      logic     advance;
   } seq_type;

   // datapath to sequencer
   typedef struct packed {
      logic start;
      logic final_cell;
      logic k_end;
   } status_type;

   // control program
   function automatic ctrl_type microcode(step_type s);
      ctrl_type w;
      w = '{accept: 1'b0, emit: 1'b0, tile_lo: 1'b0, tile_hi: 1'b0,
            attr_write: 1'b0, attr_start: 1'b0, attr_emit: 1'b0, pos_inc: 1'b0,
            last_sel: LAST_NONE, cond: COND_NEVER, target: STEP_IDLE};
      case (s)
         STEP_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_NOT_START;
            w.target = STEP_IDLE;
         end
         STEP_TILE0: begin
            w.emit       = 1'b1;
            w.attr_write = 1'b1;
         end
         STEP_TILE1: begin
            w.emit    = 1'b1;
            w.tile_lo = 1'b1;
         end
         STEP_TILE2: begin
            w.emit    = 1'b1;
            w.tile_hi = 1'b1;
         end
         STEP_TILE3: begin
            w.emit     = 1'b1;
            w.tile_lo  = 1'b1;
            w.tile_hi  = 1'b1;
            w.pos_inc  = 1'b1;
            w.last_sel = LAST_NOT_FINAL;
            w.cond     = COND_NOT_FINAL;
            w.target   = STEP_IDLE;
         end
         STEP_APRIME: begin
            w.attr_start = 1'b1;
         end
         STEP_AEMIT: begin
            w.emit      = 1'b1;
            w.attr_emit = 1'b1;
            w.last_sel  = LAST_K_END;
            w.cond      = COND_NOT_K_END;
            w.target    = STEP_AEMIT;
         end
         default: begin
            w.cond   = COND_NEVER;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/mtnx_ram.sv =====
// ----------------------------------------------------------------------------
// mtnx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtnx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mtnx_sequencer.sv =====
// ----------------------------------------------------------------------------
// mtnx_sequencer
// Step counter over the control program, with conditional jumps.
// ----------------------------------------------------------------------------
module mtnx_sequencer
   import mtnx_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       rsp_stall,
   input  status_type status,
   output seq_type    seq
);

   step_type pc_ff, pc_in;
   ctrl_type word;
   logic     advance;
   logic     take;

   // fetch
   assign word    = microcode(pc_ff);
   assign advance = !word.emit || !rsp_stall;

   // condition select
   always_comb begin
      case (word.cond)
         COND_NEVER:     take = 1'b0;
         COND_NOT_START: take = !status.start;
         COND_NOT_FINAL: take = !status.final_cell;
         COND_NOT_K_END: take = !status.k_end;
         default:        take = 1'b0;
      endcase
   end

   // next step
   always_comb begin
      pc_in = pc_ff;
      if (advance) begin
         if (take) begin
            pc_in = word.target;
         end else if (pc_ff == STEP_W'(STEP_COUNT - 1)) begin
            pc_in = STEP_IDLE;
         end else begin
            pc_in = pc_ff + STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   assign seq.word    = word;
   assign seq.advance = advance;

endmodule

// ===== rtl/mtnx_datapath.sv =====
// ----------------------------------------------------------------------------
// mtnx_datapath
// Map position, attribute store, base register and write formatting.
// ----------------------------------------------------------------------------
module mtnx_datapath
   import mtnx_pkg::*;
#(
   parameter int MAP_CELLS       = MAP_CELLS_DEF,
   parameter int ATTRIBUTE_BYTES = ATTRIBUTE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  seq_type     seq,
   output status_type  status,
   input  logic        req_valid,
   input  logic        req_action,
   input  logic [7:0]  req_metatile_byte,
   input  logic        csr_valid,
   input  logic [15:0] csr_write_data,
   output logic [15:0] rsp_video_address,
   output logic [7:0]  rsp_video_data,
   output logic        rsp_last
);

   localparam int AW = (ATTRIBUTE_BYTES > 1) ? $clog2(ATTRIBUTE_BYTES) : 1;

   logic [15:0]          base_ff;
   logic [7:0]           pos_ff, pos_in;
   logic [7:0]           byte_ff;
   logic [AW-1:0]        k_ff, k_in;
   logic [ATTRIBUTE_BYTES-1:0] valid_ff, valid_in;
   logic                 rvalid_ff, rvalid_in;

   logic [5:0]           idx;
   logic                 in_store;
   logic [2:0]           shift;
   logic [7:0]           pal_bits;
   logic [7:0]           stored;
   logic                 begin_map;
   logic                 rd_en, wr_en;
   logic [AW-1:0]        rd_addr;
   logic [7:0]           rd_data, wr_data;
   logic [15:0]          offset;
   logic [7:0]           tile;

   // cell decode: row is pos[7:4], column is pos[3:0]
   assign idx      = {pos_ff[7:5], pos_ff[3:1]};
   assign in_store = ({2'b00, idx} < 8'(ATTRIBUTE_BYTES));
   assign shift    = {pos_ff[4], pos_ff[0], 1'b0};
   assign pal_bits = 8'({6'b0, byte_ff[7:6]} << shift);
   assign stored   = rvalid_ff ? rd_data : 8'h00;

   // status back to the sequencer
   assign status.start      = req_valid && req_action && (pos_ff < 8'(MAP_CELLS));
   assign status.final_cell = (pos_ff == 8'(MAP_CELLS - 1));
   assign status.k_end      = (k_ff == AW'(ATTRIBUTE_BYTES - 1));

   assign begin_map = seq.word.accept && req_valid && !req_action;

   // attribute store access
   always_comb begin
      rd_en     = 1'b0;
      rd_addr   = idx[AW-1:0];
      wr_en     = seq.word.attr_write && in_store;
      wr_data   = stored | pal_bits;
      k_in      = k_ff;
      valid_in  = valid_ff;
      rvalid_in = rvalid_ff;
      if (seq.word.accept && status.start) begin
         rd_en     = 1'b1;
         rd_addr   = idx[AW-1:0];
         rvalid_in = in_store && valid_ff[idx[AW-1:0]];
      end
      if (seq.word.attr_start) begin
         rd_en     = 1'b1;
         rd_addr   = '0;
         k_in      = '0;
         rvalid_in = valid_ff[0];
      end
      if (seq.word.attr_emit && seq.advance && !status.k_end) begin
         rd_en     = 1'b1;
         rd_addr   = k_ff + AW'(1);
         k_in      = k_ff + AW'(1);
         rvalid_in = valid_ff[k_ff + AW'(1)];
      end
      if (wr_en) begin
         valid_in[idx[AW-1:0]] = 1'b1;
      end
      if (begin_map) begin
         valid_in = '0;
      end
   end

   mtnx_ram #(
      .WIDTH (8),
      .DEPTH (ATTRIBUTE_BYTES)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // map position
   always_comb begin
      pos_in = pos_ff;
      if (begin_map) begin
         pos_in = 8'h00;
      end else if (seq.word.pos_inc && seq.advance) begin
         pos_in = pos_ff + 8'h01;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= BASE_RESET;
         pos_ff   <= 8'h00;
         valid_ff <= '0;
      end else begin
         if (csr_valid) begin
            base_ff <= csr_write_data;
         end
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (seq.word.accept && status.start) begin
         byte_ff <= req_metatile_byte;
      end
      k_ff      <= k_in;
      rvalid_ff <= rvalid_in;
   end

   // write formatting: offsets 0, 1, 32, 33 and tiles t, t+1, t+16, t+17
   assign tile = {byte_ff[5:3], seq.word.tile_hi, byte_ff[2:0], seq.word.tile_lo};

   always_comb begin
      if (seq.word.attr_emit) begin
         offset = ATTR_OFFSET | 16'(k_ff);
      end else begin
         offset = {6'b0, pos_ff[7:4], seq.word.tile_hi, pos_ff[3:0], seq.word.tile_lo};
      end
   end

   assign rsp_video_address = base_ff + offset;
   assign rsp_video_data    = seq.word.attr_emit ? stored : tile;

   always_comb begin
      case (seq.word.last_sel)
         LAST_NONE:      rsp_last = 1'b0;
         LAST_NOT_FINAL: rsp_last = !status.final_cell;
         LAST_K_END:     rsp_last = status.k_end;
         default:        rsp_last = 1'b0;
      endcase
   end

endmodule

// ===== rtl/metatile_to_nametable_expander_unit.sv =====
// ----------------------------------------------------------------------------
// metatile_to_nametable_expander_unit
// Expands a metatile map into tile-map writes and packed attribute writes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/stall): action 0 begins a new map, rewinding the cell
//   position and clearing the attribute store; action 1 carries one metatile
//   byte. Each byte gives four tile-map writes on the rsp channel; the byte
//   that fills the last cell also gives one write per attribute byte, at
//   base + 0x3C0 onward. rsp_last marks the final write of each item.
//   csr channel (valid/ready, always ready) sets the map base address; write
//   it only while the block is idle.
// Timing:
//   a begin item is taken in the idle step. A metatile byte is also taken
//   there, and its writes appear one per cycle in steps TILE0 to TILE3 while
//   rsp is not stalled; the final cell then adds a priming step and one emit
//   step per attribute byte for the flush. The step counter walking the
//   control program works on one item at a time.
// Reset: synchronous; base returns to 0x2000, position and attributes clear.
// Stall: a stalled rsp item holds, and the sequencer waits in its step.
// ----------------------------------------------------------------------------
module metatile_to_nametable_expander_unit
   import mtnx_pkg::*;
#(
   parameter int MAP_CELLS       = MAP_CELLS_DEF,
   parameter int ATTRIBUTE_BYTES = ATTRIBUTE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_metatile_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_video_address,
   output logic [7:0]  rsp_video_data,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_write_data
);

   seq_type    seq;
   status_type status;

   // control program sequencer
   mtnx_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .rsp_stall (rsp_stall),
      .status    (status),
      .seq       (seq)
   );

   // datapath
   mtnx_datapath #(
      .MAP_CELLS       (MAP_CELLS),
      .ATTRIBUTE_BYTES (ATTRIBUTE_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .seq               (seq),
      .status            (status),
      .req_valid         (req_valid),
      .req_action        (req_action),
      .req_metatile_byte (req_metatile_byte),
      .csr_valid         (csr_valid),
      .csr_write_data    (csr_write_data),
      .rsp_video_address (rsp_video_address),
      .rsp_video_data    (rsp_video_data),
      .rsp_last          (rsp_last)
   );

   // handshakes
   assign req_stall = !seq.word.accept;
   assign rsp_valid = seq.word.emit;
   assign csr_ready = 1'b1;

endmodule
